// ----- src/wfv_pkg.sv -----
// ============================================================================
// wfv_pkg
// Shared widths, codes, gains and the CORDIC arctangent table of the
// waypoint follower.
// ============================================================================
`default_nettype none

package wfv_pkg;

    localparam int ROUTE_DEPTH_DEF  = 1024;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CW  = 40;   // coordinate width
    localparam int DW  = 41;   // coordinate difference width
    localparam int AB  = 16;   // angle and angular speed width
    localparam int SW  = 15;   // linear speed width
    localparam int EW  = 18;   // heading error width
    localparam int ZW  = 22;   // CORDIC angle accumulator, Q.16
    localparam int PW  = 35;   // signed product register width
    localparam int QW  = 30;   // square root operand width
    localparam int RW  = 15;   // square root result width

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_POSE   = 2'd2;

    localparam logic [1:0] ST_LOADED   = 2'd0;
    localparam logic [1:0] ST_DRIVING  = 2'd1;
    localparam logic [1:0] ST_FINISHED = 2'd2;
    localparam logic [1:0] ST_STOPPED  = 2'd3;

    localparam logic [2:0] REG_SKIP     = 3'd0;
    localparam logic [2:0] REG_ARRIVE   = 3'd1;
    localparam logic [2:0] REG_DEADBAND = 3'd2;
    localparam logic [2:0] REG_TURN     = 3'd3;
    localparam logic [2:0] REG_LIN_LIM  = 3'd4;
    localparam logic [2:0] REG_ANG_LIM  = 3'd5;
    localparam logic [2:0] REG_GAIN     = 3'd6;
    localparam logic [2:0] REG_PATROL   = 3'd7;

    localparam logic signed [ZW-1:0] PI_Q16     = ZW'(205887);
    localparam logic signed [EW-1:0] PI_Q13     = EW'(25736);
    localparam logic signed [EW-1:0] TWO_PI_Q13 = EW'(51472);

    localparam logic signed [PW-1:0] K_STEP     = PW'(19661);
    localparam logic signed [PW-1:0] K_ANG_DAMP = PW'(52429);
    localparam logic signed [PW-1:0] K_LIN_DAMP = PW'(58982);

    localparam logic [SW-1:0] MIN_SPEED = SW'(1229);
    localparam logic [63:0]   NEAR_SQ   = 64'd1681;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:    v = ZW'(51472);
            5'd1:    v = ZW'(30386);
            5'd2:    v = ZW'(16055);
            5'd3:    v = ZW'(8150);
            5'd4:    v = ZW'(4091);
            5'd5:    v = ZW'(2047);
            5'd6:    v = ZW'(1024);
            5'd7:    v = ZW'(512);
            5'd8:    v = ZW'(256);
            5'd9:    v = ZW'(128);
            5'd10:   v = ZW'(64);
            5'd11:   v = ZW'(32);
            5'd12:   v = ZW'(16);
            5'd13:   v = ZW'(8);
            5'd14:   v = ZW'(4);
            5'd15:   v = ZW'(2);
            5'd16:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/waypoint_follower_velocity_control_core.sv -----
// Sequence: clear and append beats go from decode straight to emit; a pose
//   beat adds the bearing and speed update and one route read per point
//   dropped by the skip walk or examined by a trim walk. The route memory
//   read port and the iterative CORDIC set the length of a pose beat.
// Throughput: one beat at a time; the next beat is taken while a result waits.
// Reset: synchronous active low; route table contents stay undefined.
// ============================================================================
// waypoint_follower_velocity_control_core
// Route table, skip and trim walks, bearing, heading error and speed update.
// ============================================================================
`default_nettype none

module waypoint_follower_velocity_control_core
    import wfv_pkg::*;
#(
    parameter int ROUTE_DEPTH  = ROUTE_DEPTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_opcode,
    input  wire logic signed [CW-1:0] i_waypoint_x,
    input  wire logic signed [CW-1:0] i_waypoint_y,
    input  wire logic signed [CW-1:0] i_pose_x,
    input  wire logic signed [CW-1:0] i_pose_y,
    input  wire logic signed [AB-1:0] i_heading,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_status,
    output logic                      o_command_valid,
    output logic [SW-1:0]             o_linear_speed,
    output logic signed [AB-1:0]      o_angular_speed,
    output logic signed [CW-1:0]      o_target_x,
    output logic signed [CW-1:0]      o_target_y,
    output logic signed [AB-1:0]      o_target_bearing
);

    localparam int AW = $clog2(ROUTE_DEPTH);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] DEPTH_L = LW'(ROUTE_DEPTH);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DECODE    = 5'd1;
    localparam logic [4:0] S_SKIP_RD   = 5'd2;
    localparam logic [4:0] S_DA        = 5'd3;
    localparam logic [4:0] S_DB        = 5'd4;
    localparam logic [4:0] S_DC        = 5'd5;
    localparam logic [4:0] S_DD        = 5'd6;
    localparam logic [4:0] S_BRG       = 5'd7;
    localparam logic [4:0] S_BRG_W     = 5'd8;
    localparam logic [4:0] S_ERR       = 5'd9;
    localparam logic [4:0] S_ANG1      = 5'd10;
    localparam logic [4:0] S_ANG2      = 5'd11;
    localparam logic [4:0] S_ANG3      = 5'd12;
    localparam logic [4:0] S_LIN0      = 5'd13;
    localparam logic [4:0] S_SQ_W      = 5'd14;
    localparam logic [4:0] S_LIN1      = 5'd15;
    localparam logic [4:0] S_LIN2      = 5'd16;
    localparam logic [4:0] S_LIN3      = 5'd17;
    localparam logic [4:0] S_LIN4      = 5'd18;
    localparam logic [4:0] S_LIN5      = 5'd19;
    localparam logic [4:0] S_ARR       = 5'd20;
    localparam logic [4:0] S_END       = 5'd21;
    localparam logic [4:0] S_TRIM_INIT = 5'd22;
    localparam logic [4:0] S_TRIM_RD   = 5'd23;
    localparam logic [4:0] S_TRIM_NEXT = 5'd24;
    localparam logic [4:0] S_EMIT      = 5'd25;

    // configuration
    logic [15:0] r_skip, r_arrive, r_gain;
    logic [14:0] r_deadband, r_turn, r_lin_lim, r_ang_lim;
    logic        r_patrol;

    // architectural state
    logic [LW-1:0]        r_len, r_cur;
    logic                 r_rev, r_started, r_loaded;
    logic [SW-1:0]        r_lin, r_st;
    logic signed [AB-1:0] r_ang;

    // work registers
    logic [4:0]           r_state;
    logic [1:0]           r_op;
    logic signed [CW-1:0] r_wx, r_wy, r_px, r_py;
    logic signed [AB-1:0] r_hd;
    logic                 r_trim_mode, r_trim_first, r_done;
    logic [31:0]          r_sk, r_ak;
    logic [29:0]          r_lim2;
    logic signed [DW-1:0] r_dx, r_dy;
    logic [CW-1:0]        r_rx, r_ry;
    logic [61:0]          r_sqx;
    logic                 r_sat;
    logic [63:0]          r_d2, r_bd;
    logic [LW-1:0]        r_k, r_n, r_best;
    logic signed [AB-1:0] r_b;
    logic signed [EW-1:0] r_err;
    logic [EW-1:0]        r_aerr;
    logic signed [PW-1:0] r_prod;
    logic signed [AB:0]   r_a;
    logic [SW-1:0]        r_c, r_tgt, r_v;

    // result being built and output register
    logic [1:0]           r_res_status;
    logic                 r_res_cmd;
    logic [SW-1:0]        r_res_lin;
    logic signed [AB-1:0] r_res_ang, r_res_brg;
    logic [CW-1:0]        r_res_tx, r_res_ty;
    logic                 r_out_valid;
    logic [1:0]           r_o_status;
    logic                 r_o_cmd;
    logic [SW-1:0]        r_o_lin;
    logic signed [AB-1:0] r_o_ang, r_o_brg;
    logic [CW-1:0]        r_o_tx, r_o_ty;

    // memory and unit interfaces
    logic            w_mem_we, w_mem_re;
    logic [AW-1:0]   w_raddr;
    logic [2*CW-1:0] w_rdata;
    logic            w_cordic_start, w_cordic_done;
    logic signed [AB-1:0] w_bearing;
    logic            w_sqrt_start, w_sqrt_done;
    logic [RW-1:0]   w_root;

    // combinational helpers
    logic [LW-1:0]        w_psize, w_pos, w_idx, w_cur_inc;
    logic signed [DW-1:0] w_dx, w_dy;
    logic [DW-1:0]        w_ax, w_ay;
    logic [61:0]          w_sqx, w_sqy;
    logic signed [EW-1:0] w_err0, w_err;
    logic [EW-1:0]        w_aerr;
    logic signed [PW-1:0] w_lim_a, w_lim_v, w_a_sum, w_a_prod, w_ang_rnd;
    logic signed [PW-1:0] w_comp_prod, w_tgt_sum, w_v_sum, w_v_prod, w_lin_rnd;
    logic [16:0]          w_comp;
    logic [SW-1:0]        w_c_lim, w_c_root;
    logic                 w_cfg_we, w_accept;

    always_comb begin
        w_psize   = (r_cur < r_len) ? r_len - r_cur : '0;
        w_pos     = r_cur + (r_trim_mode ? r_k : '0);
        w_idx     = r_rev ? r_len - LW'(1) - w_pos : w_pos;
        w_raddr   = w_idx[AW-1:0];
        w_cur_inc = r_cur + LW'(1);

        w_dx = DW'($signed(w_rdata[CW-1:0])) - DW'(r_px);
        w_dy = DW'($signed(w_rdata[2*CW-1:CW])) - DW'(r_py);
        w_ax = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
        w_ay = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
        w_sqx = w_ax[30:0] * w_ax[30:0];
        w_sqy = w_ay[30:0] * w_ay[30:0];

        // wrap heading error into the half-turn range
        w_err0 = EW'(r_b) - EW'(r_hd);
        if (w_err0 > PI_Q13) begin
            w_err = w_err0 - TWO_PI_Q13;
        end else if (w_err0 < -PI_Q13) begin
            w_err = w_err0 + TWO_PI_Q13;
        end else begin
            w_err = w_err0;
        end
        w_aerr = r_err[EW-1] ? EW'(-r_err) : EW'(r_err);

        w_lim_a   = PW'($signed({1'b0, r_ang_lim}));
        w_lim_v   = PW'($signed({1'b0, r_lin_lim}));
        w_a_sum   = PW'(r_ang) + ((r_prod + PW'(65536)) >>> 17);
        w_a_prod  = PW'(r_a) * K_ANG_DAMP;
        w_ang_rnd = (w_a_prod + PW'(32768)) >>> 16;

        w_comp      = 17'h10000 - {1'b0, r_gain};
        w_comp_prod = PW'($signed({1'b0, w_comp})) * PW'($signed({1'b0, r_st}));
        w_tgt_sum   = (r_prod + w_comp_prod + PW'(32768)) >>> 16;
        w_v_sum     = PW'($signed({1'b0, r_lin})) + ((r_prod + PW'(32768)) >>> 16);
        w_v_prod    = PW'($signed({1'b0, r_v})) * K_LIN_DAMP;
        w_lin_rnd   = (w_v_prod + PW'(32768)) >>> 16;

        w_c_lim  = (r_lin_lim < MIN_SPEED) ? MIN_SPEED : r_lin_lim;
        w_c_root = (w_root < MIN_SPEED) ? MIN_SPEED : w_root;

        w_mem_we       = (r_state == S_DECODE) && (r_op == OP_APPEND) && (r_len < DEPTH_L);
        w_mem_re       = ((r_state == S_SKIP_RD) && (w_psize != '0))
                         || (r_state == S_TRIM_RD);
        w_cordic_start = (r_state == S_BRG) && (r_d2 > NEAR_SQ);
        w_sqrt_start   = (r_state == S_LIN0) && ({34'b0, r_lim2} > r_d2);
    end

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip     <= 16'd1434;
            r_arrive   <= 16'd410;
            r_deadband <= 15'd410;
            r_turn     <= 15'd8579;
            r_lin_lim  <= 15'd12288;
            r_ang_lim  <= 15'd5325;
            r_gain     <= 16'd13107;
            r_patrol   <= 1'b0;
        end else if (w_cfg_we) begin
            unique case (paddr[4:2])
                REG_SKIP:     r_skip     <= pwdata[15:0];
                REG_ARRIVE:   r_arrive   <= pwdata[15:0];
                REG_DEADBAND: r_deadband <= pwdata[14:0];
                REG_TURN:     r_turn     <= pwdata[14:0];
                REG_LIN_LIM:  r_lin_lim  <= pwdata[14:0];
                REG_ANG_LIM:  r_ang_lim  <= pwdata[14:0];
                REG_GAIN:     r_gain     <= pwdata[15:0];
                REG_PATROL:   r_patrol   <= pwdata[0];
                default:      r_patrol   <= r_patrol;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SKIP:     prdata = {16'b0, r_skip};
            REG_ARRIVE:   prdata = {16'b0, r_arrive};
            REG_DEADBAND: prdata = {17'b0, r_deadband};
            REG_TURN:     prdata = {17'b0, r_turn};
            REG_LIN_LIM:  prdata = {17'b0, r_lin_lim};
            REG_ANG_LIM:  prdata = {17'b0, r_ang_lim};
            REG_GAIN:     prdata = {16'b0, r_gain};
            REG_PATROL:   prdata = {31'b0, r_patrol};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_cur       <= '0;
            r_rev       <= 1'b0;
            r_started   <= 1'b0;
            r_loaded    <= 1'b0;
            r_lin       <= '0;
            r_ang       <= '0;
            r_st        <= '0;
            r_trim_mode <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= i_opcode;
                        r_wx    <= i_waypoint_x;
                        r_wy    <= i_waypoint_y;
                        r_px    <= i_pose_x;
                        r_py    <= i_pose_y;
                        r_hd    <= i_heading;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_sk         <= r_skip * r_skip;
                    r_ak         <= r_arrive * r_arrive;
                    r_lim2       <= r_lin_lim * r_lin_lim;
                    r_res_status <= ST_STOPPED;
                    r_res_cmd    <= 1'b0;
                    r_res_lin    <= '0;
                    r_res_ang    <= '0;
                    r_res_tx     <= '0;
                    r_res_ty     <= '0;
                    r_res_brg    <= '0;
                    r_trim_mode  <= 1'b0;
                    r_state      <= S_EMIT;
                    priority case (r_op)
                        OP_CLEAR: begin
                            r_len        <= '0;
                            r_cur        <= '0;
                            r_loaded     <= 1'b0;
                            r_rev        <= 1'b0;
                            r_started    <= 1'b0;
                            r_res_status <= ST_LOADED;
                        end
                        OP_APPEND: begin
                            if (r_len < DEPTH_L) begin
                                r_len        <= r_len + LW'(1);
                                r_loaded     <= 1'b1;
                                r_cur        <= '0;
                                r_rev        <= 1'b0;
                                r_res_status <= ST_LOADED;
                            end
                        end
                        OP_POSE: begin
                            if (!r_patrol) begin
                                if (r_loaded) begin
                                    r_state <= S_SKIP_RD;
                                end
                            end else if (!r_started) begin
                                if (w_psize != '0) begin
                                    r_trim_first <= 1'b1;
                                    r_state      <= S_TRIM_INIT;
                                end else begin
                                    r_lin     <= '0;
                                    r_ang     <= '0;
                                    r_res_cmd <= 1'b1;
                                end
                            end else if (w_psize != '0) begin
                                r_state <= S_SKIP_RD;
                            end
                        end
                        default: r_res_status <= ST_STOPPED;
                    endcase
                end
                S_SKIP_RD: begin
                    if (w_psize == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_END;
                    end else begin
                        r_state <= S_DA;
                    end
                end
                S_DA: begin
                    r_dx    <= w_dx;
                    r_dy    <= w_dy;
                    r_rx    <= w_rdata[CW-1:0];
                    r_ry    <= w_rdata[2*CW-1:CW];
                    r_state <= S_DB;
                end
                S_DB: begin
                    r_sqx   <= w_sqx;
                    // an axis offset of 2^31 or more saturates the distance
                    r_sat   <= (|w_ax[DW-1:31]) || (|w_ay[DW-1:31]);
                    r_state <= S_DC;
                end
                S_DC: begin
                    r_d2    <= r_sat ? '1 : {2'b0, r_sqx} + {2'b0, w_sqy};
                    r_state <= S_DD;
                end
                S_DD: begin
                    if (r_trim_mode) begin
                        if ((r_k == '0) || (r_d2 < r_bd)) begin
                            r_bd   <= r_d2;
                            r_best <= r_k;
                        end
                        r_k     <= r_k + LW'(1);
                        r_state <= S_TRIM_NEXT;
                    end else if (r_d2 < {32'b0, r_sk}) begin
                        r_cur   <= w_cur_inc;
                        r_state <= S_SKIP_RD;
                    end else begin
                        r_state <= S_BRG;
                    end
                end
                S_BRG: begin
                    if (r_d2 > NEAR_SQ) begin
                        r_state <= S_BRG_W;
                    end else begin
                        r_b     <= '0;
                        r_state <= S_ERR;
                    end
                end
                S_BRG_W: begin
                    if (w_cordic_done) begin
                        r_b     <= w_bearing;
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= w_err;
                    r_state <= S_ANG1;
                end
                S_ANG1: begin
                    r_aerr <= w_aerr;
                    if (w_aerr < EW'(r_deadband)) begin
                        r_ang   <= '0;
                        r_state <= S_LIN0;
                    end else begin
                        r_prod  <= PW'(r_err) * K_STEP;
                        r_state <= S_ANG2;
                    end
                end
                S_ANG2: begin
                    if (w_a_sum > w_lim_a) begin
                        r_a <= (AB+1)'(w_lim_a);
                    end else if (w_a_sum < -w_lim_a) begin
                        r_a <= (AB+1)'(-w_lim_a);
                    end else begin
                        r_a <= (AB+1)'(w_a_sum);
                    end
                    r_state <= S_ANG3;
                end
                S_ANG3: begin
                    r_ang   <= AB'(w_ang_rnd);
                    r_state <= S_LIN0;
                end
                S_LIN0: begin
                    if ({34'b0, r_lim2} <= r_d2) begin
                        r_c     <= w_c_lim;
                        r_state <= S_LIN1;
                    end else begin
                        r_state <= S_SQ_W;
                    end
                end
                S_SQ_W: begin
                    if (w_sqrt_done) begin
                        r_c     <= w_c_root;
                        r_state <= S_LIN1;
                    end
                end
                S_LIN1: begin
                    r_prod  <= PW'($signed({1'b0, r_gain})) * PW'($signed({1'b0, r_c}));
                    r_state <= S_LIN2;
                end
                S_LIN2: begin
                    r_tgt   <= SW'(w_tgt_sum);
                    r_state <= S_LIN3;
                end
                S_LIN3: begin
                    r_prod  <= (PW'($signed({1'b0, r_tgt})) - PW'($signed({1'b0, r_lin})))
                               * K_STEP;
                    r_state <= S_LIN4;
                end
                S_LIN4: begin
                    if (w_v_sum < PW'(0)) begin
                        r_v <= '0;
                    end else if (w_v_sum > w_lim_v) begin
                        r_v <= r_lin_lim;
                    end else begin
                        r_v <= SW'(w_v_sum);
                    end
                    r_state <= S_LIN5;
                end
                S_LIN5: begin
                    r_st <= r_tgt;
                    // turn in place when the heading error is too large
                    r_lin   <= (r_aerr > EW'(r_turn)) ? '0 : SW'(w_lin_rnd);
                    r_state <= S_ARR;
                end
                S_ARR: begin
                    r_res_cmd <= 1'b1;
                    r_res_lin <= r_lin;
                    r_res_ang <= r_ang;
                    r_res_tx  <= r_rx;
                    r_res_ty  <= r_ry;
                    r_res_brg <= r_b;
                    if (r_d2 < {32'b0, r_ak}) begin
                        r_cur  <= w_cur_inc;
                        r_done <= !(w_cur_inc < r_len);
                    end else begin
                        r_done <= 1'b0;
                    end
                    r_state <= S_END;
                end
                S_END: begin
                    r_state <= S_EMIT;
                    if (!r_patrol) begin
                        r_res_status <= r_done ? ST_FINISHED : ST_DRIVING;
                        if (r_done) begin
                            r_len    <= '0;
                            r_cur    <= '0;
                            r_loaded <= 1'b0;
                            r_rev    <= 1'b0;
                        end
                    end else begin
                        r_res_status <= ST_DRIVING;
                        if (r_done) begin
                            r_cur <= '0;
                            if (!r_rev) begin
                                r_rev <= 1'b1;
                            end else begin
                                // forward pass restarts at the closest point
                                r_rev        <= 1'b0;
                                r_trim_first <= 1'b0;
                                r_state      <= S_TRIM_INIT;
                            end
                        end
                    end
                end
                S_TRIM_INIT: begin
                    r_n         <= w_psize;
                    r_k         <= '0;
                    r_best      <= '0;
                    r_trim_mode <= 1'b1;
                    r_state     <= (w_psize == '0) ? S_TRIM_NEXT : S_TRIM_RD;
                end
                S_TRIM_RD: begin
                    r_state <= S_DA;
                end
                S_TRIM_NEXT: begin
                    if (r_k >= r_n) begin
                        r_cur       <= r_cur + r_best;
                        r_trim_mode <= 1'b0;
                        if (r_trim_first) begin
                            r_started    <= 1'b1;
                            r_res_status <= ST_DRIVING;
                        end
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_TRIM_RD;
                    end
                end
                S_EMIT: begin
                    // hold the result until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_res_status;
                        r_o_cmd     <= r_res_cmd;
                        r_o_lin     <= r_res_lin;
                        r_o_ang     <= r_res_ang;
                        r_o_tx      <= r_res_tx;
                        r_o_ty      <= r_res_ty;
                        r_o_brg     <= r_res_brg;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_command_valid  = r_o_cmd;
    assign o_linear_speed   = r_o_lin;
    assign o_angular_speed  = r_o_ang;
    assign o_target_x       = $signed(r_o_tx);
    assign o_target_y       = $signed(r_o_ty);
    assign o_target_bearing = r_o_brg;

    // appends finish before any later beat reads, so no forwarding is needed
    wfv_route_mem #(
        .DEPTH (ROUTE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata ({r_wy, r_wx}),
        .i_re    (w_mem_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    wfv_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_cordic_start),
        .i_dx      (r_dx),
        .i_dy      (r_dy),
        .o_done    (w_cordic_done),
        .o_bearing (w_bearing)
    );

    wfv_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (r_d2[QW-1:0]),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

endmodule

`default_nettype wire

// ----- src/wfv_route_mem.sv -----
// ============================================================================
// wfv_route_mem
// Route table: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module wfv_route_mem
    import wfv_pkg::*;
#(
    parameter int DEPTH = ROUTE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire logic [2*CW-1:0] i_wdata,
    input  wire logic            i_re,
    input  wire logic [AW-1:0]   i_raddr,
    output logic      [2*CW-1:0] o_rdata
);

    logic [2*CW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/wfv_cordic.sv -----
// ============================================================================
// wfv_cordic
// Iterative vectoring CORDIC: normalizes the vector one bit a cycle, then
// runs one rotation a cycle and returns the bearing in Q3.13.
// ============================================================================
`default_nettype none

module wfv_cordic
    import wfv_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [DW-1:0] i_dx,
    input  wire logic signed [DW-1:0] i_dy,
    output logic                      o_done,
    output logic signed [AB-1:0]      o_bearing
);

    localparam int IW = $clog2(STEPS);
    localparam int XW = DW + 1;
    localparam logic [IW-1:0] LAST = IW'(STEPS - 1);
    localparam logic [XW-1:0] HI_MAG = XW'(1) << 30;
    localparam logic [XW-1:0] LO_MAG = XW'(1) << 29;
    localparam logic signed [ZW-1:0] Z_LIM = ZW'(25736);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_NORM = 2'd1;
    localparam logic [1:0] C_ROT  = 2'd2;
    localparam logic [1:0] C_OUT  = 2'd3;

    logic [1:0]           r_state;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [IW-1:0]        r_i;
    logic                 r_done;
    logic signed [AB-1:0] r_bearing;

    logic [XW-1:0]        w_ax, w_ay, w_mx;
    logic signed [XW-1:0] w_sx, w_sy;
    logic signed [ZW-1:0] w_zr;

    always_comb begin
        w_ax = r_x[XW-1] ? XW'(-r_x) : XW'(r_x);
        w_ay = r_y[XW-1] ? XW'(-r_y) : XW'(r_y);
        w_mx = (w_ax > w_ay) ? w_ax : w_ay;
        w_sx = r_x >>> r_i;
        w_sy = r_y >>> r_i;
        w_zr = (r_z + ZW'(4)) >>> 3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_x     <= XW'(i_dx);
                        r_y     <= XW'(i_dy);
                        r_state <= C_NORM;
                    end
                end
                C_NORM: begin
                    if (w_mx >= HI_MAG) begin
                        r_x <= r_x >>> 1;
                        r_y <= r_y >>> 1;
                    end else if (w_mx < LO_MAG) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        // fold the left half plane onto the right one
                        if (r_x[XW-1]) begin
                            r_z <= r_y[XW-1] ? -PI_Q16 : PI_Q16;
                            r_x <= -r_x;
                            r_y <= -r_y;
                        end else begin
                            r_z <= '0;
                        end
                        r_i     <= '0;
                        r_state <= C_ROT;
                    end
                end
                C_ROT: begin
                    if (!r_y[XW-1]) begin
                        r_x <= r_x + w_sy;
                        r_y <= r_y - w_sx;
                        r_z <= r_z + atan_q16(5'(r_i));
                    end else begin
                        r_x <= r_x - w_sy;
                        r_y <= r_y + w_sx;
                        r_z <= r_z - atan_q16(5'(r_i));
                    end
                    if (r_i == LAST) begin
                        r_state <= C_OUT;
                    end else begin
                        r_i <= r_i + IW'(1);
                    end
                end
                C_OUT: begin
                    if (w_zr > Z_LIM) begin
                        r_bearing <= AB'(Z_LIM);
                    end else if (w_zr < -Z_LIM) begin
                        r_bearing <= AB'(-Z_LIM);
                    end else begin
                        r_bearing <= AB'(w_zr);
                    end
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_bearing = r_bearing;

endmodule

`default_nettype wire

// ----- src/wfv_isqrt.sv -----
// ============================================================================
// wfv_isqrt
// Digit-by-digit integer square root, one result bit a cycle.
// ============================================================================
`default_nettype none

module wfv_isqrt
    import wfv_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [QW-1:0] i_value,
    output logic               o_done,
    output logic [RW-1:0]      o_root
);

    logic          r_busy, r_done;
    logic [QW-1:0] r_v, r_r, r_bit;
    logic [QW:0]   w_sum;

    assign w_sum = {1'b0, r_r} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_v    <= i_value;
                    r_r    <= '0;
                    r_bit  <= QW'(1) << (QW - 2);
                    r_busy <= 1'b1;
                end
            end else begin
                if ({1'b0, r_v} >= w_sum) begin
                    r_v <= r_v - w_sum[QW-1:0];
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == QW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[RW-1:0];

endmodule

`default_nettype wire

// ----- src/wfv_checker.sv -----
// ============================================================================
// wfv_checker
// Port-level checks on the result channel of the waypoint follower.
// ============================================================================
`default_nettype none

module wfv_checker
    import wfv_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [1:0]           o_status,
    input wire logic                 o_command_valid,
    input wire logic [SW-1:0]        o_linear_speed,
    input wire logic signed [AB-1:0] o_angular_speed,
    input wire logic signed [CW-1:0] o_target_x,
    input wire logic signed [CW-1:0] o_target_y,
    input wire logic signed [AB-1:0] o_target_bearing
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_target_x) && $stable(o_linear_speed))
        else $error("result beat changed while stalled");

    a_no_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_command_valid |-> o_linear_speed == '0
            && o_angular_speed == '0 && o_target_x == '0 && o_target_y == '0
            && o_target_bearing == '0)
        else $error("fields set without a command");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_STOPPED |-> o_linear_speed == '0
            && o_angular_speed == '0)
        else $error("stopped status with nonzero speed");

    a_load_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_LOADED |-> !o_command_valid)
        else $error("load beat carries a command");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind waypoint_follower_velocity_control_core wfv_checker u_wfv_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_command_valid  (o_command_valid),
    .o_linear_speed   (o_linear_speed),
    .o_angular_speed  (o_angular_speed),
    .o_target_x       (o_target_x),
    .o_target_y       (o_target_y),
    .o_target_bearing (o_target_bearing)
);

`default_nettype wire
